/* rtl/damped_sliding_dft_bank_core_assert.svh */
// Assertion macros for the checker of the sliding DFT bank.
`ifndef DAMPED_SLIDING_DFT_BANK_CORE_ASSERT_SVH
`define DAMPED_SLIDING_DFT_BANK_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held low.
`define DSDB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define DSDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dsdb_pkg.sv */
// Types, constants and elaboration-time helpers for the sliding DFT bank.
`default_nettype none
package dsdb_pkg;

  localparam int BIN_W = 40;
  localparam int TW_W  = 17;
  localparam int INC_W = 20;
  localparam int ENERGY_W = 62;

  localparam longint PI_Q30 = 64'sd3373259426;

  localparam longint SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam longint COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] sample;
  } dsdb_in_t;

  typedef struct packed {
    logic [7:0]          bin_number;
    logic [ENERGY_W-1:0] energy;
    logic                last;
    logic                window_full;
  } dsdb_out_t;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clr;
    logic tw_sh;
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic o_sh;
  } dsdb_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWLD,
    ST_INC,
    ST_RND,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_UPD3,
    ST_DRAIN
  } dsdb_state_e;

  // Shift right with rounding half away from zero.
  function automatic longint rnd_sh(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  // Damping raised to the window length, Q1.16, rounded at each step.
  function automatic longint damp_pow(int d, int n);
    longint p;
    p = 65536;
    for (int i = 0; i < n; i++) begin
      p = rnd_sh(p * longint'(d), 16);
    end
    return p;
  endfunction

  function automatic logic signed [BIN_W-1:0] sat40(logic signed [42:0] v);
    if ((v[42:39] == 4'b0000) || (v[42:39] == 4'b1111)) begin
      return v[BIN_W-1:0];
    end else if (v[42]) begin
      return {1'b1, {(BIN_W-1){1'b0}}};
    end else begin
      return {1'b0, {(BIN_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/damped_sliding_dft_bank_core.sv */
// Top level of the damped sliding DFT bank: sequencer, delay line, twiddle ROM, cell row, energy pipeline.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per item:
// a push carries a Q1.15 sample, a clear zeroes bins, pointer and fill count and
// produces no output. Output channel (out_valid_o / out_ready_i / out_data_o)
// gives NUM_BINS beats per push, lowest bin first, last set on the final one.
// first_bin is to be written by the user through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block itself does not enforce this. A push holds
// the input through accept, leaving-term multiply and round, four update stages
// in all cells at once, and the shift of the results out of the cell row bin by
// bin. The first push after reset or a first_bin write also loads twiddles into
// the row before its update. A clear leaves the input open. Once the shift-out
// starts, each energy beat passes the magnitude, square and sum registers.
// Reset clears the bins, pointer, fill count and first_bin at once; the delay
// line is not cleared, entries not yet written since a clear read as zero via
// the fill count. When the receiver stalls, the shift-out and the energy
// pipeline hold, and the next item is taken once the row is empty.
`default_nettype none
module damped_sliding_dft_bank_core
  import dsdb_pkg::*;
#(
  parameter int WINDOW_LEN  = 256,
  parameter int NUM_BINS    = 16,
  parameter int DAMPING_Q16 = 65470
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dsdb_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output dsdb_out_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int PTR_W     = $clog2(WINDOW_LEN);
  localparam int FILL_W    = $clog2(WINDOW_LEN + 1);
  localparam int CNT_W     = $clog2(NUM_BINS + 1);
  localparam int ROM_DEPTH = 256 + NUM_BINS;
  localparam int K_W       = $clog2(ROM_DEPTH);
  localparam logic signed [17:0] DPOW_S = 18'(damp_pow(DAMPING_Q16, WINDOW_LEN));

  // Damped twiddle for bin k: angle in Q2.30, folded, Taylor series in Q30.
  function automatic logic [2*TW_W-1:0] tw_calc(int k);
    longint p, x, x2, ts, tc, s, c, cr, ci;
    logic cneg;
    p    = longint'(k % WINDOW_LEN);
    x    = (2 * PI_Q30 * p + WINDOW_LEN / 2) / WINDOW_LEN;
    cneg = 1'b0;
    s    = 0;
    c    = 0;
    if (x > PI_Q30) x = x - 2 * PI_Q30;
    if (x > PI_Q30 / 2) begin
      x    = PI_Q30 - x;
      cneg = 1'b1;
    end else if (x < -(PI_Q30 / 2)) begin
      x    = -PI_Q30 - x;
      cneg = 1'b1;
    end
    x2 = rnd_sh(x * x, 30);
    ts = x;
    tc = 64'sd1 <<< 30;
    for (int n = 1; n <= 10; n++) begin
      s  = s + ts;
      c  = c + tc;
      ts = -rnd_sh(ts * x2, 30) / SIN_DIV[n-1];
      tc = -rnd_sh(tc * x2, 30) / COS_DIV[n-1];
    end
    if (cneg) c = -c;
    cr = rnd_sh(longint'(DAMPING_Q16) * c, 30);
    ci = rnd_sh(longint'(DAMPING_Q16) * s, 30);
    return {TW_W'(cr), TW_W'(ci)};
  endfunction

  logic [2*TW_W-1:0] rom_w [ROM_DEPTH];
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [2*TW_W-1:0] TwEntry = tw_calc(g);
    assign rom_w[g] = TwEntry;
  end

  dsdb_state_e state_q, state_d;
  dsdb_ctl_t   ctl;
  logic        e_vld, adv;

  logic [7:0]              first_bin_q;
  logic                    tw_ok_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [PTR_W-1:0]        ptr_q;
  logic [FILL_W-1:0]       fill_q;
  logic                    full_q;
  logic signed [15:0]      sample_q;
  logic [15:0]             rd_q;
  logic signed [34:0]      prod_q;
  logic signed [INC_W-1:0] inc_q;
  logic [2*TW_W-1:0]       tw_rd_q;
  logic [15:0]             dl_mem [WINDOW_LEN];

  logic                    accept;
  logic [K_W-1:0]          k_w;
  logic signed [16:0]      old2_w;
  logic signed [35:0]      pb_w;
  logic signed [35:0]      ps_w;
  logic signed [18:0]      rp_w;

  assign accept = in_valid_i && in_ready_o;
  assign k_w    = K_W'(first_bin_q) + K_W'(cnt_q);
  // A slot not written since the last clear still reads as zero.
  assign old2_w = (fill_q == FILL_W'(WINDOW_LEN)) ? signed'({rd_q, 1'b0}) : '0;
  assign pb_w   = 36'(prod_q) + (prod_q[34] ? 36'sd32767 : 36'sd32768);
  assign ps_w   = pb_w >>> 16;
  assign rp_w   = 19'(ps_w);

  always_comb begin
    state_d    = state_q;
    ctl        = '0;
    in_ready_o = 1'b0;
    e_vld      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.opcode == OP_CLEAR) begin
            ctl.clr = 1'b1;
          end else begin
            state_d = tw_ok_q ? ST_INC : ST_TWLD;
          end
        end
      end
      ST_TWLD: begin
        ctl.tw_sh = (cnt_q != '0);
        if (cnt_q == CNT_W'(NUM_BINS)) state_d = ST_INC;
      end
      ST_INC:  state_d = ST_RND;
      ST_RND:  state_d = ST_UPD0;
      ST_UPD0: begin
        ctl.s0  = 1'b1;
        state_d = ST_UPD1;
      end
      ST_UPD1: begin
        ctl.s1  = 1'b1;
        state_d = ST_UPD2;
      end
      ST_UPD2: begin
        ctl.s2  = 1'b1;
        state_d = ST_UPD3;
      end
      ST_UPD3: begin
        ctl.s3  = 1'b1;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        e_vld    = 1'b1;
        ctl.o_sh = adv;
        if (adv && (cnt_q == CNT_W'(NUM_BINS - 1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_bin_q <= '0;
      tw_ok_q     <= 1'b0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      full_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        first_bin_q <= cfg_wdata_i;
        tw_ok_q     <= 1'b0;
      end else if ((state_q == ST_TWLD) && (cnt_q == CNT_W'(NUM_BINS))) begin
        tw_ok_q <= 1'b1;
      end
      if (accept) begin
        cnt_q <= '0;
        if (in_data_i.opcode == OP_CLEAR) begin
          ptr_q  <= '0;
          fill_q <= '0;
        end
      end else if (state_q == ST_TWLD) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (state_q == ST_UPD3) begin
        cnt_q <= '0;
      end else if ((state_q == ST_DRAIN) && adv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_INC) begin
        ptr_q <= (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
        if (fill_q != FILL_W'(WINDOW_LEN)) begin
          fill_q <= fill_q + 1'b1;
          full_q <= (fill_q == FILL_W'(WINDOW_LEN - 1));
        end else begin
          full_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_data_i.sample;
      rd_q     <= dl_mem[ptr_q];
    end
    if (state_q == ST_TWLD) tw_rd_q <= rom_w[k_w];
    if (state_q == ST_INC) begin
      prod_q          <= DPOW_S * old2_w;
      dl_mem[ptr_q]   <= sample_q;
    end
    if (state_q == ST_RND) inc_q <= (20'(sample_q) <<< 1) - 20'(rp_w);
  end

  logic [2*TW_W-1:0]  tw_chain [NUM_BINS+1];
  logic [2*BIN_W-1:0] o_chain  [NUM_BINS+1];

  assign tw_chain[NUM_BINS] = tw_rd_q;
  assign o_chain[NUM_BINS]  = '0;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    dsdb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .inc_i  (inc_q),
      .tw_i   (tw_chain[i+1]),
      .tw_o   (tw_chain[i]),
      .o_i    (o_chain[i+1]),
      .o_o    (o_chain[i])
    );
  end

  dsdb_energy u_energy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (e_vld),
    .bin_i       (first_bin_q + 8'(cnt_q)),
    .last_i      (cnt_q == CNT_W'(NUM_BINS - 1)),
    .full_i      (full_q),
    .re_i        (signed'(o_chain[0][2*BIN_W-1:BIN_W])),
    .im_i        (signed'(o_chain[0][BIN_W-1:0])),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* rtl/dsdb_cell.sv */
// One bin cell: holds a complex bin, its twiddle and its result in the output chain.
`default_nettype none
module dsdb_cell
  import dsdb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire dsdb_ctl_t                ctl_i,
  input  wire logic signed [INC_W-1:0]  inc_i,
  input  wire logic [2*TW_W-1:0]        tw_i,
  output logic [2*TW_W-1:0]             tw_o,
  input  wire logic [2*BIN_W-1:0]       o_i,
  output logic [2*BIN_W-1:0]            o_o
);

  logic signed [BIN_W-1:0] re_q, im_q;
  logic signed [BIN_W-1:0] a_q, b_q;
  logic signed [TW_W-1:0]  tr_q, ti_q;
  logic signed [56:0]      p_ar_q, p_bi_q, p_ai_q, p_br_q;
  logic signed [57:0]      sr_q, si_q;
  logic [2*BIN_W-1:0]      o_q;

  logic signed [42:0] sum_w;
  logic signed [58:0] tr_w, ti_w;
  logic signed [58:0] shr_w, shi_w;
  logic signed [BIN_W-1:0] nr_w, ni_w;

  assign sum_w = 43'(re_q) + 43'(inc_i);

  // Symmetric rounding folds into one add: bias is one less for negative values.
  assign tr_w  = 59'(sr_q) + (sr_q[57] ? 59'sd32767 : 59'sd32768);
  assign ti_w  = 59'(si_q) + (si_q[57] ? 59'sd32767 : 59'sd32768);
  assign shr_w = tr_w >>> 16;
  assign shi_w = ti_w >>> 16;
  assign nr_w  = sat40(43'(shr_w));
  assign ni_w  = sat40(43'(shi_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= '0;
      im_q <= '0;
    end else if (ctl_i.clr) begin
      re_q <= '0;
      im_q <= '0;
    end else if (ctl_i.s3) begin
      re_q <= nr_w;
      im_q <= ni_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tw_sh) begin
      tr_q <= signed'(tw_i[2*TW_W-1:TW_W]);
      ti_q <= signed'(tw_i[TW_W-1:0]);
    end
    if (ctl_i.s0) begin
      a_q <= sat40(sum_w);
      b_q <= im_q;
    end
    if (ctl_i.s1) begin
      p_ar_q <= a_q * tr_q;
      p_bi_q <= b_q * ti_q;
      p_ai_q <= a_q * ti_q;
      p_br_q <= b_q * tr_q;
    end
    if (ctl_i.s2) begin
      sr_q <= 58'(p_ar_q) - 58'(p_bi_q);
      si_q <= 58'(p_ai_q) + 58'(p_br_q);
    end
    if (ctl_i.s3) begin
      o_q <= {nr_w, ni_w};
    end else if (ctl_i.o_sh) begin
      o_q <= o_i;
    end
  end

  assign tw_o = {tr_q, ti_q};
  assign o_o  = o_q;

endmodule
`default_nettype wire

/* rtl/dsdb_energy.sv */
// Energy pipeline: magnitude check, squares, saturating sum and the output register.
`default_nettype none
module dsdb_energy
  import dsdb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    vld_i,
  input  wire logic [7:0]              bin_i,
  input  wire logic                    last_i,
  input  wire logic                    full_i,
  input  wire logic signed [BIN_W-1:0] re_i,
  input  wire logic signed [BIN_W-1:0] im_i,
  output logic                         adv_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output dsdb_out_t                    out_data_o
);

  logic            v1_q, v2_q, v3_q;
  logic [30:0]     ma_q, mb_q;
  logic            ovf1_q, ovf2_q;
  logic [61:0]     sqa_q, sqb_q;
  logic [7:0]      bin1_q, bin2_q;
  logic            last1_q, last2_q, full1_q, full2_q;
  dsdb_out_t       out_q;

  logic [BIN_W-1:0] abs_re_w, abs_im_w;
  logic [62:0]      sum_w;

  assign adv_o    = !v3_q || out_ready_i;
  assign abs_re_w = re_i[BIN_W-1] ? BIN_W'(-re_i) : BIN_W'(re_i);
  assign abs_im_w = im_i[BIN_W-1] ? BIN_W'(-im_i) : BIN_W'(im_i);
  assign sum_w    = 63'(sqa_q) + 63'(sqb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_o) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      ma_q    <= abs_re_w[30:0];
      mb_q    <= abs_im_w[30:0];
      ovf1_q  <= (|abs_re_w[BIN_W-1:31]) || (|abs_im_w[BIN_W-1:31]);
      bin1_q  <= bin_i;
      last1_q <= last_i;
      full1_q <= full_i;

      sqa_q   <= ma_q * ma_q;
      sqb_q   <= mb_q * mb_q;
      ovf2_q  <= ovf1_q;
      bin2_q  <= bin1_q;
      last2_q <= last1_q;
      full2_q <= full1_q;

      out_q.bin_number  <= bin2_q;
      out_q.energy      <= (ovf2_q || sum_w[62]) ? ENERGY_MAX : sum_w[61:0];
      out_q.last        <= last2_q;
      out_q.window_full <= full2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* rtl/dsdb_checker.sv */
// Port-level checker for the sliding DFT bank and its bind to the top level.
`default_nettype none
`include "damped_sliding_dft_bank_core_assert.svh"
module dsdb_checker
  import dsdb_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire dsdb_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire dsdb_out_t out_data_o
);

  logic push_acc_w, clear_acc_w, out_stall_w;

  assign push_acc_w  = in_valid_i && in_ready_o && (in_data_i.opcode == OP_PUSH);
  assign clear_acc_w = in_valid_i && in_ready_o && (in_data_i.opcode == OP_CLEAR);
  assign out_stall_w = out_valid_o && !out_ready_i;

  // A stalled output beat stays offered with the same payload.
  `DSDB_ASSERT(a_out_hold, clk_i, rst_ni, out_stall_w |=> out_valid_o, "stalled beat dropped")
  `DSDB_ASSERT(a_out_stable, clk_i, rst_ni, out_stall_w |=> $stable(out_data_o), "stalled beat changed")

  // A pushed sample closes the input right after it is taken.
  `DSDB_ASSERT(a_push_busy, clk_i, rst_ni, push_acc_w |=> !in_ready_o, "input open after a push")

  // A clear does not close the input.
  `DSDB_ASSERT(a_clear_quick, clk_i, rst_ni, clear_acc_w |=> in_ready_o, "input closed after a clear")

  // No output beat is offered while reset is held.
  `DSDB_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind damped_sliding_dft_bank_core dsdb_checker u_dsdb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
